>>> rtl/vdr_pkg.sv
// Shared types, command codes and helpers for the vertex weld and remap block.
package vdr_pkg;

  // Default store depth.
  localparam int MaxVerticesDef = 256;

  // Width of the cell index carried by a query (covers the full parameter range).
  localparam int HitIdxW = 16;

  // Command codes.
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_INDEX  = 2'd2;

  // Value reported when no index exists.
  localparam logic [31:0] NO_INDEX = 32'hFFFF_FFFF;

  // Query token handed from cell to cell along the match chain.
  typedef struct packed {
    logic               vld;
    logic [95:0]        key;
    logic               hit;
    logic               new_grp;
    logic [HitIdxW-1:0] idx;
  } vdr_query_t;

  // Fold negative zero onto positive zero.
  function automatic logic [31:0] fold_zero(input logic [31:0] v);
    return (v == 32'h8000_0000) ? 32'h0 : v;
  endfunction

endpackage

>>> rtl/vdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vdr_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/vdr_key_cell.sv
// One key cell of the match chain: holds a stored position and passes the query on.
module vdr_key_cell
  import vdr_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        live,
  input  logic        wr_en,
  input  logic [95:0] wr_key,
  input  vdr_query_t  q_in,
  output vdr_query_t  q_out
);

  logic [95:0] key_r;
  logic        seen_r;
  logic        match;
  vdr_query_t  q_r;
  vdr_query_t  q_nxt;

  // Exact compare against the passing query
  assign match = q_in.vld && live && !q_in.hit && (key_r == q_in.key);

  always_comb begin
    q_nxt = q_in;
    if (match) begin
      q_nxt.hit     = 1'b1;
      q_nxt.new_grp = !seen_r;
      q_nxt.idx     = HitIdxW'(CELL_IDX);
    end
  end

  // Query stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= q_nxt.vld;
    end
    q_r.key     <= q_nxt.key;
    q_r.hit     <= q_nxt.hit;
    q_r.new_grp <= q_nxt.new_grp;
    q_r.idx     <= q_nxt.idx;
  end

  // Stored key and second-sighting mark
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r  <= wr_key;
      seen_r <= 1'b0;
    end else if (match) begin
      seen_r <= 1'b1;
    end
  end

  assign q_out = q_r;

endmodule

>>> rtl/vertex_dedup_index_remap_core.sv
// Top level: vertex welding by exact position with index remap.
//
//   channel | direction | signals
//   in_     | in        | in_valid, in_ready, in_command, in_x_bits, in_y_bits,
//           |           | in_z_bits, in_index_value
//   out_    | out       | out_valid, out_ready, out_new_index, out_is_kept,
//           |           | out_is_duplicate, out_error_flag, out_group_count,
//           |           | out_unique_count
//
// A vertex beat's query walks the key cell chain one cell per cycle; an in-range index
// beat reads the remap RAM, and other beats go straight to the result state.
// One beat is in flight at a time; in_ready is high in the idle state.
// Reset clears counts, state and out_valid; stored keys and remap table need no clearing.
// A stalled result holds in the output register and holds the block with it.
module vertex_dedup_index_remap_core
  import vdr_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVerticesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [31:0]        in_x_bits,
  input  logic [31:0]        in_y_bits,
  input  logic [31:0]        in_z_bits,
  input  logic signed [31:0] in_index_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_index,
  output logic               out_is_kept,
  output logic               out_is_duplicate,
  output logic               out_error_flag,
  output logic [7:0]         out_group_count,
  output logic [8:0]         out_unique_count
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_RD   = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] loaded_r, loaded_nxt;
  logic [CW-1:0] distinct_r, distinct_nxt;
  logic [7:0]    groups_r, groups_nxt;
  logic [31:0]   res_idx_r, res_idx_nxt;
  logic          res_kept_r, res_kept_nxt;
  logic          res_dup_r, res_dup_nxt;
  logic          res_err_r, res_err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_fire;
  logic          out_load;
  logic          tail_done;

  vdr_query_t    chain [MAX_VERTICES+1];
  vdr_query_t    tail;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_wdata;
  logic [IW-1:0] ram_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign tail      = chain[MAX_VERTICES];
  assign tail_done = (state_r == S_SCAN) && tail.vld;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Query launch into the head of the chain
  always_comb begin
    chain[0].vld     = in_fire && (in_command == CMD_VERTEX) &&
                       (loaded_r != CW'(MAX_VERTICES));
    chain[0].key     = {fold_zero(in_x_bits), fold_zero(in_y_bits), fold_zero(in_z_bits)};
    chain[0].hit     = 1'b0;
    chain[0].new_grp = 1'b0;
    chain[0].idx     = '0;
  end

  // Key cell chain
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    vdr_key_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .live  (CW'(i) < distinct_r),
      .wr_en (tail_done && !tail.hit && (distinct_r[IW-1:0] == IW'(i))),
      .wr_key(tail.key),
      .q_in  (chain[i]),
      .q_out (chain[i+1])
    );
  end

  // Per-vertex compact index table
  assign ram_we    = tail_done;
  assign ram_waddr = loaded_r[IW-1:0];
  assign ram_wdata = tail.hit ? tail.idx[IW-1:0] : distinct_r[IW-1:0];

  vdr_ram #(
    .W(IW),
    .D(MAX_VERTICES)
  ) u_remap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_index_value[IW-1:0]),
    .rdata(ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    loaded_nxt   = loaded_r;
    distinct_nxt = distinct_r;
    groups_nxt   = groups_r;
    res_idx_nxt  = res_idx_r;
    res_kept_nxt = res_kept_r;
    res_dup_nxt  = res_dup_r;
    res_err_nxt  = res_err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_idx_nxt  = NO_INDEX;
          res_kept_nxt = 1'b0;
          res_dup_nxt  = 1'b0;
          res_err_nxt  = 1'b1;
          state_nxt    = S_FIN;
          unique case (in_command)
            CMD_START: begin
              loaded_nxt   = '0;
              distinct_nxt = '0;
              groups_nxt   = '0;
              res_idx_nxt  = '0;
              res_err_nxt  = 1'b0;
            end
            CMD_VERTEX: begin
              if (loaded_r != CW'(MAX_VERTICES)) begin
                state_nxt = S_SCAN;
              end
            end
            CMD_INDEX: begin
              if (in_index_value[31]) begin
                res_idx_nxt = in_index_value;
                res_err_nxt = 1'b0;
              end else if ($unsigned(in_index_value) < 32'(loaded_r)) begin
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tail.vld) begin
          loaded_nxt  = loaded_r + CW'(1);
          res_err_nxt = 1'b0;
          if (tail.hit) begin
            res_idx_nxt = 32'(tail.idx[IW-1:0]);
            res_dup_nxt = 1'b1;
            if (tail.new_grp && (groups_r != 8'hFF)) begin
              groups_nxt = groups_r + 8'd1;
            end
          end else begin
            res_idx_nxt  = 32'(distinct_r);
            res_kept_nxt = 1'b1;
            distinct_nxt = distinct_r + CW'(1);
          end
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        res_idx_nxt = 32'(ram_rdata);
        res_err_nxt = 1'b0;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output beat handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      distinct_r  <= '0;
      groups_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      distinct_r  <= distinct_nxt;
      groups_r    <= groups_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result and output payload registers
  always_ff @(posedge clk) begin
    res_idx_r  <= res_idx_nxt;
    res_kept_r <= res_kept_nxt;
    res_dup_r  <= res_dup_nxt;
    res_err_r  <= res_err_nxt;
    if (out_load) begin
      out_new_index    <= res_idx_r;
      out_is_kept      <= res_kept_r;
      out_is_duplicate <= res_dup_r;
      out_error_flag   <= res_err_r;
      out_group_count  <= groups_r;
      out_unique_count <= 9'(distinct_r);
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_distinct_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= loaded_r)
    else $error("distinct count exceeds loaded count");

  a_groups_le_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    32'(groups_r) <= 32'(distinct_r))
    else $error("group count exceeds distinct count");

  a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (state_r == S_SCAN))
    else $error("query left the chain outside a scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second beat accepted while busy");

endmodule
